// ===== rtl/ealu_pkg.sv =====
// ----------------------------------------------------------------------------
// ealu_pkg
// Shared types and constants of the eight-bit ALU with flags: opcode codes,
// operation kinds, flag bit positions and the result bundle.
// ----------------------------------------------------------------------------
package ealu_pkg;

  // Flag bit positions inside the 4-bit ZNHC field
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Register code of the accumulator
  localparam logic [2:0] REG_A = 3'd7;
  localparam logic [2:0] REG_NONE = 3'd0;

  // Opcode group patterns
  localparam logic [1:0] GRP_ALU_REG   = 2'b10;
  localparam logic [7:0] MASK_IMM      = 8'hC7;
  localparam logic [7:0] PAT_ALU_IMM   = 8'hC6;
  localparam logic [7:0] PAT_INC_R8    = 8'h04;
  localparam logic [7:0] PAT_DEC_R8    = 8'h05;

  // Accumulator opcodes
  localparam logic [7:0] OP_RLCA = 8'h07;
  localparam logic [7:0] OP_RRCA = 8'h0F;
  localparam logic [7:0] OP_RLA  = 8'h17;
  localparam logic [7:0] OP_RRA  = 8'h1F;
  localparam logic [7:0] OP_DAA  = 8'h27;
  localparam logic [7:0] OP_CPL  = 8'h2F;
  localparam logic [7:0] OP_SCF  = 8'h37;
  localparam logic [7:0] OP_CCF  = 8'h3F;

  // Decimal adjust constants
  localparam logic [7:0] DAA_HI_ADJ    = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ    = 8'h06;
  localparam logic [7:0] DAA_LIMIT     = 8'h99;
  localparam logic [3:0] BCD_DIGIT_MAX = 4'h9;

  // Operation kind in opcode bits 5:3 of the ALU group
  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_ADC = 3'd1,
    KIND_SUB = 3'd2,
    KIND_SBC = 3'd3,
    KIND_AND = 3'd4,
    KIND_XOR = 3'd5,
    KIND_OR  = 3'd6,
    KIND_CP  = 3'd7
  } alu_kind_t;

  // One result beat
  typedef struct packed {
    logic [7:0] result;
    logic [7:0] acc_out;
    logic [3:0] flags_out;
    logic [2:0] dest_index;
    logic       writes_back;
    logic       handled;
  } alu_result_t;

endpackage

// ===== rtl/ealu_core.sv =====
// ----------------------------------------------------------------------------
// ealu_core
// Combinational datapath: decodes the opcode and computes the written value,
// new accumulator, ZNHC flags, destination code and handled mark.
// ----------------------------------------------------------------------------
module ealu_core (
  input  logic [7:0]           opcode,
  input  logic [7:0]           operand,
  input  logic [7:0]           acc_in,
  input  logic [3:0]           flags_in,
  output ealu_pkg::alu_result_t res
);

  // Shared add and subtract with carry-in
  logic       cin;
  logic       carry_use;
  logic [8:0] add_sum;
  logic [4:0] add_half;
  logic [8:0] sub_diff;
  logic [4:0] sub_half;
  logic [7:0] inc_val;
  logic [7:0] dec_val;
  logic [7:0] daa_val;
  logic       daa_c;

  // Only ADC and SBC take the carry in; compare ignores it
  assign cin       = flags_in[ealu_pkg::FLAG_C];
  assign carry_use = cin & opcode[3] & ~opcode[5];
  assign add_sum   = {1'b0, acc_in} + {1'b0, operand} + {8'd0, carry_use};
  assign add_half  = {1'b0, acc_in[3:0]} + {1'b0, operand[3:0]} + {4'd0, carry_use};
  assign sub_diff  = {1'b0, acc_in} - {1'b0, operand} - {8'd0, carry_use};
  assign sub_half  = {1'b0, acc_in[3:0]} - {1'b0, operand[3:0]} - {4'd0, carry_use};
  assign inc_val   = operand + 8'd1;
  assign dec_val   = operand - 8'd1;

  // Decimal adjust of the accumulator
  always_comb begin
    daa_val = acc_in;
    daa_c   = cin;
    if (flags_in[ealu_pkg::FLAG_N]) begin
      if (cin) daa_val = daa_val - ealu_pkg::DAA_HI_ADJ;
      if (flags_in[ealu_pkg::FLAG_H]) daa_val = daa_val - ealu_pkg::DAA_LO_ADJ;
    end else begin
      if (cin || (acc_in > ealu_pkg::DAA_LIMIT)) begin
        daa_val = daa_val + ealu_pkg::DAA_HI_ADJ;
        daa_c   = 1'b1;
      end
      if (flags_in[ealu_pkg::FLAG_H] || (acc_in[3:0] > ealu_pkg::BCD_DIGIT_MAX)) begin
        daa_val = daa_val + ealu_pkg::DAA_LO_ADJ;
      end
    end
  end

  // Decode and select
  always_comb begin
    logic [7:0] val;
    logic [3:0] fl;
    val = 8'd0;
    fl  = flags_in;
    res.result      = 8'd0;
    res.acc_out     = acc_in;
    res.flags_out   = flags_in;
    res.dest_index  = ealu_pkg::REG_NONE;
    res.writes_back = 1'b0;
    res.handled     = 1'b1;

    if ((opcode[7:6] == ealu_pkg::GRP_ALU_REG) ||
        ((opcode & ealu_pkg::MASK_IMM) == ealu_pkg::PAT_ALU_IMM)) begin
      // Eight-bit arithmetic and logic on A
      fl = 4'd0;
      unique case (ealu_pkg::alu_kind_t'(opcode[5:3]))
        ealu_pkg::KIND_ADD, ealu_pkg::KIND_ADC: begin
          val = add_sum[7:0];
          fl[ealu_pkg::FLAG_H] = add_half[4];
          fl[ealu_pkg::FLAG_C] = add_sum[8];
        end
        ealu_pkg::KIND_SUB, ealu_pkg::KIND_SBC, ealu_pkg::KIND_CP: begin
          val = sub_diff[7:0];
          fl[ealu_pkg::FLAG_N] = 1'b1;
          fl[ealu_pkg::FLAG_H] = sub_half[4];
          fl[ealu_pkg::FLAG_C] = sub_diff[8];
        end
        ealu_pkg::KIND_AND: begin
          val = acc_in & operand;
          fl[ealu_pkg::FLAG_H] = 1'b1;
        end
        ealu_pkg::KIND_XOR: val = acc_in ^ operand;
        default:            val = acc_in | operand;
      endcase
      fl[ealu_pkg::FLAG_Z] = (val == 8'd0);
      res.flags_out  = fl;
      res.dest_index = ealu_pkg::REG_A;
      if (ealu_pkg::alu_kind_t'(opcode[5:3]) != ealu_pkg::KIND_CP) begin
        res.result      = val;
        res.acc_out     = val;
        res.writes_back = 1'b1;
      end
    end else if (((opcode & ealu_pkg::MASK_IMM) == ealu_pkg::PAT_INC_R8) ||
                 ((opcode & ealu_pkg::MASK_IMM) == ealu_pkg::PAT_DEC_R8)) begin
      // Increment or decrement of an 8-bit register, carry kept
      fl[ealu_pkg::FLAG_N] = opcode[0];
      if (opcode[0]) begin
        val = dec_val;
        fl[ealu_pkg::FLAG_H] = (operand[3:0] == 4'h0);
      end else begin
        val = inc_val;
        fl[ealu_pkg::FLAG_H] = (operand[3:0] == 4'hF);
      end
      fl[ealu_pkg::FLAG_Z] = (val == 8'd0);
      res.result      = val;
      res.flags_out   = fl;
      res.dest_index  = opcode[5:3];
      res.writes_back = 1'b1;
      if (opcode[5:3] == ealu_pkg::REG_A) res.acc_out = val;
    end else begin
      // Accumulator and flag operations
      val = acc_in;
      unique case (opcode)
        ealu_pkg::OP_RLCA: begin
          val = {acc_in[6:0], acc_in[7]};
          fl  = {3'd0, acc_in[7]};
        end
        ealu_pkg::OP_RRCA: begin
          val = {acc_in[0], acc_in[7:1]};
          fl  = {3'd0, acc_in[0]};
        end
        ealu_pkg::OP_RLA: begin
          val = {acc_in[6:0], cin};
          fl  = {3'd0, acc_in[7]};
        end
        ealu_pkg::OP_RRA: begin
          val = {cin, acc_in[7:1]};
          fl  = {3'd0, acc_in[0]};
        end
        ealu_pkg::OP_DAA: begin
          val = daa_val;
          fl  = 4'd0;
          fl[ealu_pkg::FLAG_Z] = (daa_val == 8'd0);
          fl[ealu_pkg::FLAG_N] = flags_in[ealu_pkg::FLAG_N];
          fl[ealu_pkg::FLAG_C] = daa_c;
        end
        ealu_pkg::OP_CPL: begin
          val = ~acc_in;
          fl[ealu_pkg::FLAG_N] = 1'b1;
          fl[ealu_pkg::FLAG_H] = 1'b1;
        end
        ealu_pkg::OP_SCF: begin
          fl = {flags_in[ealu_pkg::FLAG_Z], 3'b001};
        end
        ealu_pkg::OP_CCF: begin
          fl = {flags_in[ealu_pkg::FLAG_Z], 2'b00, ~cin};
        end
        default: begin
          res.handled = 1'b0;
        end
      endcase
      if (res.handled) begin
        res.result      = val;
        res.acc_out     = val;
        res.flags_out   = fl;
        res.dest_index  = ealu_pkg::REG_A;
        res.writes_back = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/eight_bit_alu_with_flags_unit.sv =====
// A beat taken into the input register moves on to the result register and is
// then on the result ports, marked by done, for one cycle.
// Throughput: one beat per cycle; busy is low whenever rst is low.
// The receiver cannot stall; the input register and result register keep
// the two sides apart. rst (synchronous) drops any beat in flight.
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_unit
// Top level: input register, combinational ALU core, result register.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] opcode,
  input  logic [7:0] operand,
  input  logic [7:0] acc_in,
  input  logic [3:0] flags_in,
  output logic       done,
  output logic [7:0] result,
  output logic [7:0] acc_out,
  output logic [3:0] flags_out,
  output logic [2:0] dest_index,
  output logic       writes_back,
  output logic       handled
);

  logic                  in_valid;
  logic [7:0]            in_opcode;
  logic [7:0]            in_operand;
  logic [7:0]            in_acc;
  logic [3:0]            in_flags;
  ealu_pkg::alu_result_t core_res;
  ealu_pkg::alu_result_t out_res;

  // Refuse beats only while in reset
  assign busy = rst;

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_opcode  <= opcode;
      in_operand <= operand;
      in_acc     <= acc_in;
      in_flags   <= flags_in;
    end
  end

  ealu_core u_core (
    .opcode   (in_opcode),
    .operand  (in_operand),
    .acc_in   (in_acc),
    .flags_in (in_flags),
    .res      (core_res)
  );

  // Advance the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_res <= core_res;
    end
  end

  assign result      = out_res.result;
  assign acc_out     = out_res.acc_out;
  assign flags_out   = out_res.flags_out;
  assign dest_index  = out_res.dest_index;
  assign writes_back = out_res.writes_back;
  assign handled     = out_res.handled;

endmodule

// ===== rtl/ealu_checker.sv =====
// ----------------------------------------------------------------------------
// ealu_checker
// Port-level checks on beat timing and result consistency of the ALU unit.
// ----------------------------------------------------------------------------
module ealu_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [7:0] acc_in,
  input logic       done,
  input logic [7:0] result,
  input logic [7:0] acc_out,
  input logic [2:0] dest_index,
  input logic       writes_back,
  input logic       handled
);

  // Every accepted beat comes out, marked by done
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted beat produced no result");

  // No result without a matching earlier start
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("result without accepted beat");

  // Unknown opcodes write nothing and keep A
  a_unhandled: assert property (@(posedge clk) disable iff (rst)
    (done && !handled) |-> (!writes_back && (dest_index == ealu_pkg::REG_NONE) &&
                            (acc_out == $past(acc_in, 2))))
    else $error("unhandled opcode changed state");

  // A write to A shows the same value on acc_out
  a_acc_write: assert property (@(posedge clk) disable iff (rst)
    (done && writes_back && (dest_index == ealu_pkg::REG_A)) |-> (acc_out == result))
    else $error("accumulator write mismatch");

endmodule

bind eight_bit_alu_with_flags_unit ealu_checker u_ealu_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .acc_in      (acc_in),
  .done        (done),
  .result      (result),
  .acc_out     (acc_out),
  .dest_index  (dest_index),
  .writes_back (writes_back),
  .handled     (handled)
);
